// File: hdl/acccpu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acccpu_pkg
// Shared types, codes and the instruction length decode of the accumulator CPU.
// ---------------------------------------------------------------------------
package acccpu_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    localparam logic [7:0] OP_NOP  = 8'h18;
    localparam logic [7:0] OP_HALT = 8'h19;

    localparam logic [2:0] FN_AND = 3'd0;
    localparam logic [2:0] FN_OR  = 3'd1;
    localparam logic [2:0] FN_XOR = 3'd2;
    localparam logic [2:0] FN_ADD = 3'd3;
    localparam logic [2:0] FN_SUB = 3'd4;
    localparam logic [2:0] FN_INC = 3'd5;
    localparam logic [2:0] FN_DEC = 3'd6;
    localparam logic [2:0] FN_NOT = 3'd7;

    // Operand and destination modes.
    localparam logic [1:0] MD_IND   = 2'd0;
    localparam logic [1:0] MD_ACC   = 2'd1;
    localparam logic [1:0] MD_MAR   = 2'd2;
    localparam logic [1:0] MD_MEM   = 2'd3;
    localparam logic [1:0] SM_CONST = 2'd2;

    // Load and store methods.
    localparam logic [1:0] LM_ADDR  = 2'd0;
    localparam logic [1:0] LM_CONST = 2'd1;
    localparam logic [1:0] LM_IND   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  wb;
    } t_item;

    // Queue status from the front part.
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    // Back part status toward the front part.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_stat;

    function automatic logic [2:0] ins_len(input logic [7:0] op);
        logic [1:0] d;
        logic [1:0] s;
        d = op[3:2];
        s = op[1:0];
        if (op[7:3] == 5'b00010) begin
            ins_len = 3'd3;
        end else if (op[7]) begin
            if (d == MD_MEM) begin
                ins_len = (s < 2'd2) ? 3'd3 : (3'({1'b0, s}) + 3'd2);
            end else if (d == MD_MAR) begin
                ins_len = (s >= 2'd2) ? 3'd3 : 3'd1;
            end else begin
                ins_len = (s == 2'd2) ? 3'd2 : ((s == 2'd3) ? 3'd3 : 3'd1);
            end
        end else if (op[7:4] == 4'd0) begin
            case (op[2:0])
                3'd0, 3'd4, 3'd5: ins_len = 3'd3;
                3'd1:             ins_len = 3'd2;
                default:          ins_len = 3'd1;
            endcase
        end else begin
            ins_len = 3'd1;
        end
    endfunction

endpackage

// File: hdl/acccpu_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acccpu_front
// Accepts host command beats into a two-entry queue for the execution side.
// ---------------------------------------------------------------------------
module acccpu_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  acccpu_pkg::t_item        i_item,
    input  acccpu_pkg::t_back_stat   i_back,
    output acccpu_pkg::t_q_stat      o_stat,
    output acccpu_pkg::t_item        o_item
);

    acccpu_pkg::t_item r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign push = i_start && !o_stat.full;
    assign pop  = i_back.pop && o_stat.valid;

    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2) || i_back.clearing;
    assign o_item       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) n_cnt = r_cnt + 2'd1;
        if (!push && pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_item;
    end

endmodule

// File: hdl/acccpu_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acccpu_back
// Executes queued commands against the registers and the single-port memory.
// ---------------------------------------------------------------------------
module acccpu_back #(
    parameter int MEM_AW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  acccpu_pkg::t_q_stat      i_q,
    input  acccpu_pkg::t_item        i_item,
    output acccpu_pkg::t_back_stat   o_stat,
    output logic                     o_done,
    output logic [7:0]               o_read_byte,
    output logic [15:0]              o_prog_counter,
    output logic [7:0]               o_accum,
    output logic [15:0]              o_addr_reg,
    output logic                     o_halted,
    output logic                     o_illegal_op
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CMD   = 4'd2;
    localparam logic [3:0] S_RBW   = 4'd3;
    localparam logic [3:0] S_OPW   = 4'd4;
    localparam logic [3:0] S_OPR   = 4'd5;
    localparam logic [3:0] S_OPC   = 4'd6;
    localparam logic [3:0] S_D1    = 4'd7;
    localparam logic [3:0] S_D1W   = 4'd8;
    localparam logic [3:0] S_D2    = 4'd9;
    localparam logic [3:0] S_D2W   = 4'd10;
    localparam logic [3:0] S_EXE   = 4'd11;
    localparam logic [3:0] S_WR2   = 4'd12;
    localparam logic [3:0] S_HRD   = 4'd13;
    localparam logic [3:0] S_HRW   = 4'd14;

    logic [7:0] mem [2**MEM_AW];
    logic [7:0] r_rdata;

    logic [3:0]        r_state;
    logic [MEM_AW-1:0] r_clr;
    logic [15:0]       r_pc, r_mar;
    logic [7:0]        r_acc, r_op, r_b1, r_b2, r_b3, r_b4, r_x, r_y, r_rb;
    logic [1:0]        r_cnt;
    logic              r_done, r_halted, r_ill;
    acccpu_pkg::t_item r_it;

    // Marks that at least one command has been taken since reset.
    logic r_valid_item;

    logic [15:0] m_addr;
    logic        m_we;
    logic [7:0]  m_wdata;
    logic        pop;

    // Decode of the current instruction.
    logic [1:0]  d, s, lm;
    logic [2:0]  fn, len;
    logic        is_alu, is_ldst, is_br, need_rd, st_mar2;
    logic [15:0] a12, a34, addr1, addr2, dv, sv, res, next_pc, st_t;
    logic        neg, zero, taken, we1;
    logic [15:0] w1_addr;
    logic [7:0]  w1_data;

    assign d       = r_op[3:2];
    assign s       = r_op[1:0];
    assign lm      = r_op[1:0];
    assign fn      = r_op[6:4];
    assign len     = acccpu_pkg::ins_len(r_op);
    assign is_alu  = r_op[7];
    assign is_ldst = (r_op[7:4] == 4'd0);
    assign is_br   = (r_op[7:3] == 5'b00010);
    assign need_rd = is_alu || (is_ldst && r_op[3]);
    assign a12     = {r_b1, r_b2};
    assign a34     = {r_b3, r_b4};
    assign neg     = r_acc[7];
    assign zero    = (r_acc == 8'd0);
    assign st_t    = (lm == acccpu_pkg::LM_ADDR) ? a12 : r_mar;
    assign st_mar2 = is_ldst && !r_op[3] && r_op[2]
                     && (lm == acccpu_pkg::LM_ADDR || lm == acccpu_pkg::LM_IND);

    always_comb begin
        if (is_alu) begin
            if (d == acccpu_pkg::MD_IND)      addr1 = r_mar;
            else if (d == acccpu_pkg::MD_MEM) addr1 = a12;
            else if (s == acccpu_pkg::MD_IND) addr1 = r_mar;
            else                              addr1 = a12;
            case (d)
                acccpu_pkg::MD_MEM: addr2 = (s == acccpu_pkg::MD_IND) ? r_mar : a34;
                acccpu_pkg::MD_MAR: addr2 = a12 + 16'd1;
                default:            addr2 = (s == acccpu_pkg::MD_IND) ? r_mar : a12;
            endcase
        end else begin
            addr1 = (lm == acccpu_pkg::LM_IND) ? r_mar : a12;
            addr2 = addr1 + 16'd1;
        end
    end

    always_comb begin
        case (d)
            acccpu_pkg::MD_IND: dv = {8'd0, r_x};
            acccpu_pkg::MD_ACC: dv = {8'd0, r_acc};
            acccpu_pkg::MD_MAR: dv = r_mar;
            default:            dv = {8'd0, r_x};
        endcase
        case (s)
            acccpu_pkg::MD_IND:
                sv = (d == acccpu_pkg::MD_IND || d == acccpu_pkg::MD_MEM) ?
                     {8'd0, r_y} : {8'd0, r_x};
            acccpu_pkg::MD_ACC: sv = {8'd0, r_acc};
            acccpu_pkg::SM_CONST:
                sv = (d == acccpu_pkg::MD_MAR) ? a12 :
                     ((d == acccpu_pkg::MD_MEM) ? {8'd0, r_b3} : {8'd0, r_b1});
            default:
                sv = (d == acccpu_pkg::MD_MAR) ? {r_x, r_y} :
                     ((d == acccpu_pkg::MD_ACC) ? {8'd0, r_x} : {8'd0, r_y});
        endcase
        case (fn)
            acccpu_pkg::FN_AND: res = dv & sv;
            acccpu_pkg::FN_OR:  res = dv | sv;
            acccpu_pkg::FN_XOR: res = dv ^ sv;
            acccpu_pkg::FN_ADD: res = dv + sv;
            acccpu_pkg::FN_SUB: res = dv - sv;
            acccpu_pkg::FN_INC: res = dv + 16'd1;
            acccpu_pkg::FN_DEC: res = dv - 16'd1;
            default:            res = ~dv;
        endcase
    end

    always_comb begin
        case (r_op[2:0])
            3'd0:    taken = 1'b1;
            3'd1:    taken = zero;
            3'd2:    taken = !zero;
            3'd3:    taken = neg;
            3'd4:    taken = neg || zero;
            3'd5:    taken = !neg && !zero;
            3'd6:    taken = !neg;
            default: taken = 1'b0;
        endcase
        next_pc = (is_br && taken) ? a12 : (r_pc + 16'(len));
    end

    // First write of the execute step.
    always_comb begin
        we1     = 1'b0;
        w1_addr = r_mar;
        w1_data = r_acc;
        if (is_alu) begin
            we1     = (d == acccpu_pkg::MD_IND) || (d == acccpu_pkg::MD_MEM);
            w1_addr = (d == acccpu_pkg::MD_MEM) ? a12 : r_mar;
            w1_data = res[7:0];
        end else if (is_ldst && !r_op[3]) begin
            if (!r_op[2]) begin
                we1     = (lm == acccpu_pkg::LM_ADDR) || (lm == acccpu_pkg::LM_IND);
                w1_addr = (lm == acccpu_pkg::LM_ADDR) ? a12 : r_mar;
                w1_data = r_acc;
            end else begin
                we1     = st_mar2;
                w1_addr = st_t;
                w1_data = r_mar[15:8];
            end
        end
    end

    always_comb begin
        m_addr  = r_pc;
        m_we    = 1'b0;
        m_wdata = 8'd0;
        pop     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                m_addr = 16'(r_clr);
                m_we   = 1'b1;
            end
            S_IDLE:  pop = i_q.valid;
            S_CMD: begin
                if (r_it.cmd == acccpu_pkg::CMD_WRITE) begin
                    m_addr  = r_it.addr;
                    m_we    = 1'b1;
                    m_wdata = r_it.wb;
                end else if (r_it.cmd == acccpu_pkg::CMD_READ) begin
                    m_addr = r_it.addr;
                end
            end
            S_OPR:   m_addr = r_pc + 16'd1 + 16'(r_cnt);
            S_D1:    m_addr = addr1;
            S_D2:    m_addr = addr2;
            S_EXE: begin
                m_addr  = w1_addr;
                m_we    = we1;
                m_wdata = w1_data;
            end
            S_WR2: begin
                m_addr  = st_t + 16'd1;
                m_we    = 1'b1;
                m_wdata = r_mar[7:0];
            end
            S_RBW, S_OPW, S_OPC, S_D1W, S_D2W, S_HRD, S_HRW: m_addr = r_pc;
            default: m_addr = r_pc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) mem[m_addr[MEM_AW-1:0]] <= m_wdata;
        r_rdata <= mem[m_addr[MEM_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pc    <= 16'd0;
            r_acc   <= 8'd0;
            r_mar   <= 16'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_state <= S_HRD;
                end
                S_IDLE: begin
                    if (pop) begin
                        r_it    <= i_item;
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    r_rb  <= 8'd0;
                    r_ill <= 1'b0;
                    if (r_it.cmd == acccpu_pkg::CMD_READ)      r_state <= S_RBW;
                    else if (r_it.cmd == acccpu_pkg::CMD_EXEC) r_state <= S_OPW;
                    else                                       r_state <= S_HRD;
                end
                S_RBW: begin
                    r_rb    <= r_rdata;
                    r_state <= S_HRD;
                end
                S_OPW: begin
                    r_op  <= r_rdata;
                    r_cnt <= 2'd0;
                    if (r_rdata == acccpu_pkg::OP_HALT) begin
                        r_state <= S_HRD;
                    end else if (acccpu_pkg::ins_len(r_rdata) != 3'd1) begin
                        r_state <= S_OPR;
                    end else if (r_rdata[7] || (r_rdata[7:4] == 4'd0 && r_rdata[3])) begin
                        r_state <= S_D1;
                    end else begin
                        r_state <= S_EXE;
                    end
                end
                S_OPR: r_state <= S_OPC;
                S_OPC: begin
                    case (r_cnt)
                        2'd0:    r_b1 <= r_rdata;
                        2'd1:    r_b2 <= r_rdata;
                        2'd2:    r_b3 <= r_rdata;
                        default: r_b4 <= r_rdata;
                    endcase
                    if (3'({1'b0, r_cnt}) == len - 3'd2) begin
                        r_state <= need_rd ? S_D1 : S_EXE;
                    end else begin
                        r_cnt   <= r_cnt + 2'd1;
                        r_state <= S_OPR;
                    end
                end
                S_D1:  r_state <= S_D1W;
                S_D1W: begin
                    r_x     <= r_rdata;
                    r_state <= S_D2;
                end
                S_D2:  r_state <= S_D2W;
                S_D2W: begin
                    r_y     <= r_rdata;
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    r_pc <= next_pc;
                    if (is_alu) begin
                        if (d == acccpu_pkg::MD_ACC) r_acc <= res[7:0];
                        if (d == acccpu_pkg::MD_MAR) r_mar <= res;
                    end else if (is_ldst && r_op[3]) begin
                        if (!r_op[2]) begin
                            if (lm == acccpu_pkg::LM_ADDR || lm == acccpu_pkg::LM_IND)
                                r_acc <= r_x;
                            else if (lm == acccpu_pkg::LM_CONST)
                                r_acc <= r_b1;
                        end else begin
                            if (lm == acccpu_pkg::LM_ADDR || lm == acccpu_pkg::LM_IND)
                                r_mar <= {r_x, r_y};
                            else if (lm == acccpu_pkg::LM_CONST)
                                r_mar <= a12;
                        end
                    end else if (!is_br && r_op != acccpu_pkg::OP_NOP && !is_ldst) begin
                        r_ill <= 1'b1;
                    end
                    r_state <= st_mar2 ? S_WR2 : S_HRD;
                end
                S_WR2: r_state <= S_HRD;
                S_HRD: r_state <= S_HRW;
                S_HRW: begin
                    r_halted <= (r_rdata == acccpu_pkg::OP_HALT);
                    // The halt probe that ends the clearing pass reports nothing.
                    r_done   <= r_valid_item;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_valid_item <= 1'b0;
        else if (pop)  r_valid_item <= 1'b1;
    end

    assign o_stat.pop      = pop;
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_done          = r_done;
    assign o_read_byte     = r_rb;
    assign o_prog_counter  = r_pc;
    assign o_accum         = r_acc;
    assign o_addr_reg      = r_mar;
    assign o_halted        = r_halted;
    assign o_illegal_op    = r_ill;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("result strobe longer than one cycle");
    a_pop_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_state == S_CMD)) else $error("popped beat not dispatched");
    a_clear_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !pop) else $error("beat taken during clear");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE)) else $error("result outside idle");

endmodule

// File: hdl/accumulator_cpu_instruction_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// accumulator_cpu_instruction_step
// Eight-bit accumulator CPU driven by host write, read and execute commands.
// ---------------------------------------------------------------------------
// Sequencing: with the back part idle, an accepted host write or unused command goes from
// the command state to the halt probe, a read first captures its byte, and an instruction
// fetches its opcode and operand bytes and does its data reads and writes, all on one
// memory port, before the probe. While the sequencer holds a beat, a two-beat queue
// takes further beats.
// Reset: synchronous; a clearing pass zeroes 2**MEM_AW bytes, one per cycle,
// with busy high. Results are strobed for one cycle; the receiver cannot stall.
//
// The front part queues command beats; the back part is a sequencer that
// fetches the opcode, then each operand byte, then two data bytes when the
// instruction reads memory, executes, writes back and finally probes the byte
// at the new program counter to report the halted flag. Memory depth is a
// power of two set by MEM_AW; addresses wrap at 16 bits and then at the depth.
module accumulator_cpu_instruction_step #(
    parameter int MEM_AW = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_mem_addr,
    input  logic [7:0]  i_write_byte,
    output logic        o_done,
    output logic [7:0]  o_read_byte,
    output logic [15:0] o_prog_counter,
    output logic [7:0]  o_accum,
    output logic [15:0] o_addr_reg,
    output logic        o_halted,
    output logic        o_illegal_op
);

    acccpu_pkg::t_item      in_item, q_item;
    acccpu_pkg::t_q_stat    q_stat;
    acccpu_pkg::t_back_stat b_stat;

    assign in_item.cmd  = i_command;
    assign in_item.addr = i_mem_addr;
    assign in_item.wb   = i_write_byte;
    // Busy covers a full queue and the clearing pass after reset.
    assign busy = q_stat.full;

    acccpu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (in_item),
        .i_back  (b_stat),
        .o_stat  (q_stat),
        .o_item  (q_item)
    );

    acccpu_back #(.MEM_AW(MEM_AW)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (q_stat),
        .i_item         (q_item),
        .o_stat         (b_stat),
        .o_done         (o_done),
        .o_read_byte    (o_read_byte),
        .o_prog_counter (o_prog_counter),
        .o_accum        (o_accum),
        .o_addr_reg     (o_addr_reg),
        .o_halted       (o_halted),
        .o_illegal_op   (o_illegal_op)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the accumulator CPU: host writes, reads and single
// instruction steps are predicted in the bench and compared beat by beat.
// ---------------------------------------------------------------------------
module tb;

    // Cycles with no acceptance and no result before the run is declared hung.
    // The clearing pass after reset counts toward this limit.
    localparam int HANG_LIMIT = 300000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [7:0] OP_BRA = 8'h10;
    localparam logic [7:0] OP_LDA_CONST = 8'h09;

    typedef struct packed {
        logic [7:0]  rb;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [15:0] mar;
        logic        halted;
        logic        illegal;
    } t_outcome;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  wb;
        logic        typed;
        t_outcome    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = acccpu_pkg::CMD_READ;
    logic [15:0] i_mem_addr = '0;
    logic [7:0]  i_write_byte = '0;
    logic        o_done;
    logic [7:0]  o_read_byte;
    logic [15:0] o_prog_counter;
    logic [7:0]  o_accum;
    logic [15:0] o_addr_reg;
    logic        o_halted;
    logic        o_illegal_op;

    accumulator_cpu_instruction_step u_top (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the CPU state, advanced at each accepted beat.
    logic [7:0]  mem_img [0:65535];
    logic [15:0] pc_sh;
    logic [7:0]  acc_sh;
    logic [15:0] mar_sh;

    t_outcome pending_q [$];
    int       err_cnt = 0;
    int       idle_pct = 0;
    int       quiet_cycles = 0;
    int       sent_beats = 0;
    logic     beat_taken = 1'b0;

    function automatic logic [15:0] word_at(logic [15:0] a);
        return {mem_img[a], mem_img[16'(a + 16'd1)]};
    endfunction

    // Number of bytes an instruction occupies, opcode included.
    function automatic logic [15:0] op_length(logic [7:0] op);
        logic [1:0] d;
        logic [1:0] s;
        d = op[3:2];
        s = op[1:0];
        if (op[7:3] == 5'b00010) return 16'd3;
        if (op[7]) begin
            if (d == acccpu_pkg::MD_MEM) return (s < 2'd2) ? 16'd3 : 16'(s) + 16'd2;
            if (d == acccpu_pkg::MD_MAR) return (s >= 2'd2) ? 16'd3 : 16'd1;
            if (s == acccpu_pkg::SM_CONST) return 16'd2;
            return (s == acccpu_pkg::MD_MEM) ? 16'd3 : 16'd1;
        end
        if (op[7:4] == 4'd0) begin
            if (op[2:0] == 3'd0 || op[2:0] == 3'd4 || op[2:0] == 3'd5) return 16'd3;
            return (op[2:0] == 3'd1) ? 16'd2 : 16'd1;
        end
        return 16'd1;
    endfunction

    task automatic run_alu(logic [7:0] op, logic [15:0] pc);
        logic [1:0]  d;
        logic [1:0]  s;
        logic [15:0] a12;
        logic [15:0] a34;
        logic [15:0] dv;
        logic [15:0] sv;
        logic [15:0] r;
        d = op[3:2];
        s = op[1:0];
        a12 = word_at(16'(pc + 16'd1));
        a34 = word_at(16'(pc + 16'd3));
        case (d)
            acccpu_pkg::MD_IND:  dv = 16'(mem_img[mar_sh]);
            acccpu_pkg::MD_ACC:  dv = 16'(acc_sh);
            acccpu_pkg::MD_MAR:  dv = mar_sh;
            default:             dv = 16'(mem_img[a12]);
        endcase
        case (s)
            acccpu_pkg::MD_IND:   sv = 16'(mem_img[mar_sh]);
            acccpu_pkg::MD_ACC:   sv = 16'(acc_sh);
            acccpu_pkg::SM_CONST: sv = (d == acccpu_pkg::MD_MAR) ? a12 : 16'(a12[15:8]);
            default:  sv = (d == acccpu_pkg::MD_MAR) ? word_at(a12) : 16'(mem_img[a12]);
        endcase
        // A memory destination takes its constant from byte 3 and its
        // source address from bytes 3 and 4.
        if (d == acccpu_pkg::MD_MEM && s == acccpu_pkg::SM_CONST) sv = 16'(a34[15:8]);
        if (d == acccpu_pkg::MD_MEM && s == acccpu_pkg::MD_MEM) sv = 16'(mem_img[a34]);
        case (op[6:4])
            acccpu_pkg::FN_AND:  r = dv & sv;
            acccpu_pkg::FN_OR:   r = dv | sv;
            acccpu_pkg::FN_XOR:  r = dv ^ sv;
            acccpu_pkg::FN_ADD:  r = dv + sv;
            acccpu_pkg::FN_SUB:  r = dv - sv;
            acccpu_pkg::FN_INC:  r = dv + 16'd1;
            acccpu_pkg::FN_DEC:  r = dv - 16'd1;
            default:             r = ~dv;
        endcase
        case (d)
            acccpu_pkg::MD_IND:  mem_img[mar_sh] = r[7:0];
            acccpu_pkg::MD_ACC:  acc_sh = r[7:0];
            acccpu_pkg::MD_MAR:  mar_sh = r;
            default:             mem_img[a12] = r[7:0];
        endcase
    endtask

    task automatic run_load_store(logic [7:0] op, logic [15:0] pc);
        logic [1:0]  m;
        logic [15:0] a12;
        logic [15:0] t;
        m = op[1:0];
        a12 = word_at(16'(pc + 16'd1));
        case (op[3:2])
            2'b00: begin
                if (m == acccpu_pkg::LM_ADDR) mem_img[a12] = acc_sh;
                else if (m == acccpu_pkg::LM_IND) mem_img[mar_sh] = acc_sh;
            end
            2'b01: begin
                // The target is fixed before the high byte lands on it.
                t = (m == acccpu_pkg::LM_ADDR) ? a12 : mar_sh;
                if (m == acccpu_pkg::LM_ADDR || m == acccpu_pkg::LM_IND) begin
                    mem_img[t] = mar_sh[15:8];
                    mem_img[16'(t + 16'd1)] = mar_sh[7:0];
                end
            end
            2'b10: begin
                if (m == acccpu_pkg::LM_ADDR) acc_sh = mem_img[a12];
                else if (m == acccpu_pkg::LM_CONST) acc_sh = a12[15:8];
                else if (m == acccpu_pkg::LM_IND) acc_sh = mem_img[mar_sh];
            end
            default: begin
                if (m == acccpu_pkg::LM_ADDR) mar_sh = word_at(a12);
                else if (m == acccpu_pkg::LM_CONST) mar_sh = a12;
                else if (m == acccpu_pkg::LM_IND) mar_sh = word_at(mar_sh);
            end
        endcase
    endtask

    // Applies one host command to the shadow state and returns its outcome.
    task automatic cpu_step(input logic [1:0] cmd, input logic [15:0] addr,
                            input logic [7:0] wb, output t_outcome res);
        logic [7:0]  op;
        logic [15:0] pc;
        logic [15:0] nxt;
        logic        neg;
        logic        zero;
        logic        taken;
        res = '0;
        if (cmd == acccpu_pkg::CMD_WRITE) begin
            mem_img[addr] = wb;
        end else if (cmd == acccpu_pkg::CMD_READ) begin
            res.rb = mem_img[addr];
        end else if (cmd == acccpu_pkg::CMD_EXEC && mem_img[pc_sh] != acccpu_pkg::OP_HALT) begin
            pc = pc_sh;
            op = mem_img[pc];
            nxt = 16'(pc + op_length(op));
            if (op[7]) begin
                run_alu(op, pc);
            end else if (op[7:4] == 4'd0) begin
                run_load_store(op, pc);
            end else if (op[7:3] == 5'b00010) begin
                neg = acc_sh[7];
                zero = (acc_sh == 8'd0);
                case (op[2:0])
                    3'd0: taken = 1'b1;
                    3'd1: taken = zero;
                    3'd2: taken = !zero;
                    3'd3: taken = neg;
                    3'd4: taken = neg || zero;
                    3'd5: taken = !neg && !zero;
                    3'd6: taken = !neg;
                    default: taken = 1'b0;
                endcase
                if (taken) nxt = word_at(16'(pc + 16'd1));
            end else if (op != acccpu_pkg::OP_NOP) begin
                res.illegal = 1'b1;
            end
            pc_sh = nxt;
        end
        res.pc = pc_sh;
        res.acc = acc_sh;
        res.mar = mar_sh;
        res.halted = (mem_img[pc_sh] == acccpu_pkg::OP_HALT);
    endtask

    // Drives one beat, holding start until the block takes it. Called and
    // returns at a falling edge. A typed expectation replaces the predicted one.
    task automatic send_beat(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wb,
                             logic typed = 1'b0, t_outcome want = '0);
        t_outcome res;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_mem_addr <= addr;
        i_write_byte <= wb;
        do @(posedge i_clk); while (busy);
        cpu_step(cmd, addr, wb, res);
        pending_q.push_back(typed ? want : res);
        sent_beats++;
        @(negedge i_clk);
    endtask

    // Writes a random instruction at the predicted program counter and runs it.
    task automatic program_and_run();
        logic [7:0] op;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 58) op = 8'h80 | 8'($urandom_range(127));
        else if (pick < 74) op = 8'($urandom_range(15));
        else if (pick < 86) op = OP_BRA | 8'($urandom_range(7));
        else if (pick < 90) op = acccpu_pkg::OP_NOP;
        else if (pick < 93) op = acccpu_pkg::OP_HALT;
        else op = 8'($urandom_range(8'h7F, 8'h1A));
        send_beat(acccpu_pkg::CMD_WRITE, pc_sh, op);
        for (int k = 1; k <= 4; k++) begin
            // Keep operand addresses mostly inside a small window so that
            // data written earlier is read back by later instructions.
            if ((k == 1 || k == 3) && $urandom_range(3) != 0)
                send_beat(acccpu_pkg::CMD_WRITE, 16'(pc_sh + 16'(k)),
                          8'($urandom_range(1)));
            else if ($urandom_range(2) != 0)
                send_beat(acccpu_pkg::CMD_WRITE, 16'(pc_sh + 16'(k)),
                          8'($urandom_range(255)));
        end
        if ($urandom_range(3) == 0)
            send_beat(acccpu_pkg::CMD_WRITE, 16'($urandom_range(511)),
                      8'($urandom_range(255)));
        send_beat(acccpu_pkg::CMD_EXEC, 16'($urandom_range(65535)),
                  8'($urandom_range(255)));
    endtask

    task automatic cmp_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Result checker: every strobe is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome w;
        beat_taken <= start && !busy && i_rst_n;
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                $error("result strobe with no beat outstanding");
                err_cnt++;
            end else begin
                w = pending_q.pop_front();
                cmp_field("read_byte", w.rb, o_read_byte);
                cmp_field("prog_counter", w.pc, o_prog_counter);
                cmp_field("accum", w.acc, o_accum);
                cmp_field("addr_reg", w.mar, o_addr_reg);
                cmp_field("halted", w.halted, o_halted);
                cmp_field("illegal_op", w.illegal, o_illegal_op);
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if (beat_taken || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Directed rows. The typed ones read straight off reset state, address
    // extremes, HALT and the illegal opcode range.
    t_row rows [] = '{
        '{acccpu_pkg::CMD_READ,  16'hFFFF, 8'hFF, 1'b1,
          '{8'h00, 16'h0, 8'h00, 16'h0, 1'b0, 1'b0}},
        '{acccpu_pkg::CMD_WRITE, 16'hFFFF, 8'hFF, 1'b1,
          '{8'h00, 16'h0, 8'h00, 16'h0, 1'b0, 1'b0}},
        '{acccpu_pkg::CMD_READ,  16'hFFFF, 8'h00, 1'b1,
          '{8'hFF, 16'h0, 8'h00, 16'h0, 1'b0, 1'b0}},
        '{CMD_UNUSED,            16'hFFFF, 8'hFF, 1'b1,
          '{8'h00, 16'h0, 8'h00, 16'h0, 1'b0, 1'b0}},
        '{acccpu_pkg::CMD_WRITE, 16'h0000, acccpu_pkg::OP_HALT, 1'b1,
          '{8'h00, 16'h0, 8'h00, 16'h0, 1'b1, 1'b0}},
        '{acccpu_pkg::CMD_EXEC,  16'h0000, 8'h00, 1'b1,
          '{8'h00, 16'h0, 8'h00, 16'h0, 1'b1, 1'b0}},
        '{acccpu_pkg::CMD_WRITE, 16'h0000, 8'h1A, 1'b1,
          '{8'h00, 16'h0, 8'h00, 16'h0, 1'b0, 1'b0}},
        '{acccpu_pkg::CMD_EXEC,  16'h0000, 8'h00, 1'b1,
          '{8'h00, 16'h1, 8'h00, 16'h0, 1'b0, 1'b1}},
        '{acccpu_pkg::CMD_WRITE, 16'h0001, 8'h7F, 1'b1,
          '{8'h00, 16'h1, 8'h00, 16'h0, 1'b0, 1'b0}},
        '{acccpu_pkg::CMD_EXEC,  16'h0000, 8'h00, 1'b1,
          '{8'h00, 16'h2, 8'h00, 16'h0, 1'b0, 1'b1}},
        '{acccpu_pkg::CMD_WRITE, 16'h0002, OP_LDA_CONST, 1'b0, '0},
        '{acccpu_pkg::CMD_WRITE, 16'h0003, 8'h80, 1'b0, '0},
        '{acccpu_pkg::CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0},
        '{acccpu_pkg::CMD_WRITE, 16'h0004, acccpu_pkg::OP_NOP, 1'b0, '0},
        '{acccpu_pkg::CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0},
        '{acccpu_pkg::CMD_WRITE, 16'h0005, 8'hF0, 1'b0, '0},
        '{acccpu_pkg::CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0},
        '{acccpu_pkg::CMD_WRITE, 16'h0006, 8'h13, 1'b0, '0},
        '{acccpu_pkg::CMD_WRITE, 16'h0007, 8'hFF, 1'b0, '0},
        '{acccpu_pkg::CMD_WRITE, 16'h0008, 8'hFE, 1'b0, '0},
        '{acccpu_pkg::CMD_EXEC,  16'h0000, 8'h00, 1'b0, '0},
        '{acccpu_pkg::CMD_READ,  16'hFFFE, 8'h00, 1'b0, '0}
    };

    initial begin
        int phase_pct [4] = '{0, 78, 0, 34};
        foreach (mem_img[a]) mem_img[a] = 8'h00;
        pc_sh = '0;
        acc_sh = '0;
        mar_sh = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i])
            send_beat(rows[i].cmd, rows[i].addr, rows[i].wb, rows[i].typed, rows[i].want);

        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = phase_pct[ph % 4];
            // Once per run, hold off until the block has drained completely.
            if (ph == 4) begin
                start <= 1'b0;
                while (pending_q.size() != 0) @(negedge i_clk);
            end
            while (sent_beats < (ph + 1) * 147) begin
                if ($urandom_range(9) < 8) begin
                    program_and_run();
                end else begin
                    // Noise: stray reads, writes, unused commands, bare steps.
                    send_beat(2'($urandom_range(3)), 16'($urandom_range(65535)),
                              8'($urandom_range(255)));
                end
            end
        end

        start <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
